/* design/assert_macros.svh */
// Assertion macros used by the port checker in design/hbf_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define HBF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hbf assertion failed");

// Clocked assertion that also holds across reset.
`define HBF_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("hbf assertion failed");

`endif

/* design/hbf_pkg.sv */
// Shared types and constants for the harmonic bond force block.
// No dependencies.
package hbf_pkg;

  localparam int unsigned SqrtSteps    = 33;  // root bits 32..0
  localparam int unsigned DivSteps     = 48;  // quotient bits 47..0
  localparam int unsigned BackLat      = 2 + SqrtSteps + 5 + DivSteps + 1;
  localparam int unsigned FifoDepthDef = 4;

  // One classified bond: |p2-p1| per axis with its sign, k and rest length.
  typedef struct packed {
    logic [2:0][32:0] mag;
    logic [2:0]       dneg;
    logic [31:0]      k;
    logic [30:0]      len;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

/* design/hbf_front.sv */
// Input stage: takes a bond transfer, forms axis deltas and their signs.
// Depends on hbf_pkg.
module hbf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [31:0]         bead1_x_i,
  input  logic [31:0]         bead1_y_i,
  input  logic [31:0]         bead1_z_i,
  input  logic [31:0]         bead2_x_i,
  input  logic [31:0]         bead2_y_i,
  input  logic [31:0]         bead2_z_i,
  input  logic [31:0]         spring_constant_i,
  input  logic [30:0]         rest_length_i,
  input  hbf_pkg::fifo_stat_t stat_i,
  output logic                push_o,
  output hbf_pkg::item_t      item_o
);

  logic           fv_q, fv_d;
  hbf_pkg::item_t item_q, item_d;
  logic           accept;
  logic [32:0]    p1 [3];
  logic [32:0]    p2 [3];
  logic [32:0]    dlt [3];

  assign p1[0] = {bead1_x_i[31], bead1_x_i};
  assign p1[1] = {bead1_y_i[31], bead1_y_i};
  assign p1[2] = {bead1_z_i[31], bead1_z_i};
  assign p2[0] = {bead2_x_i[31], bead2_x_i};
  assign p2[1] = {bead2_y_i[31], bead2_y_i};
  assign p2[2] = {bead2_z_i[31], bead2_z_i};

  assign push_o     = fv_q && !stat_i.full;
  assign in_ready_o = !fv_q || !stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign item_o     = item_q;

  always_comb begin
    item_d = item_q;
    for (int i = 0; i < 3; i++) begin
      dlt[i]         = p2[i] - p1[i];
      item_d.dneg[i] = dlt[i][32];
      item_d.mag[i]  = dlt[i][32] ? (~dlt[i] + 33'd1) : dlt[i];
    end
    item_d.k   = spring_constant_i;
    item_d.len = rest_length_i;
  end

  always_comb begin
    fv_d = fv_q;
    if (accept) begin
      fv_d = 1'b1;
    end else if (push_o) begin
      fv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

/* design/hbf_fifo.sv */
// Short queue between the input stage and the compute pipeline.
// Depends on hbf_pkg.
module hbf_fifo #(
  parameter int unsigned Depth = hbf_pkg::FifoDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  hbf_pkg::item_t      item_i,
  input  logic                pop_i,
  output hbf_pkg::item_t      item_o,
  output hbf_pkg::fifo_stat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hbf_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* design/hbf_back.sv */
// Compute pipeline: squared distance, bitwise square root, energy and
// force products, then a radix-2 divider per axis. Depends on hbf_pkg.
module hbf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hbf_pkg::item_t      item_i,
  input  hbf_pkg::fifo_stat_t stat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [47:0]         bond_energy_o,
  output logic [47:0]         force_x_o,
  output logic [47:0]         force_y_o,
  output logic [47:0]         force_z_o,
  output logic                zero_length_o
);

  localparam int unsigned Lat = hbf_pkg::BackLat;
  localparam int unsigned Sq  = hbf_pkg::SqrtSteps;
  localparam int unsigned Dv  = hbf_pkg::DivSteps;
  localparam logic [47:0] Mag47 = 48'h8000_0000_0000;

  typedef struct packed {
    logic [47:0] energy;
    logic        zero;
    logic [2:0]  fneg;
    logic [2:0]  ovf;
    logic [48:0] dv;
  } div_pay_t;

  logic           en;
  logic [Lat-1:0] vld_q;

  assign en          = !vld_q[Lat-1] || out_ready_i;
  assign pop_o       = en && !stat_i.empty;
  assign out_valid_o = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], pop_o};
    end
  end

  // squares per axis
  logic [65:0]    a_sq_q [3];
  hbf_pkg::item_t a_it_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_sq_q[i] <= item_i.mag[i] * item_i.mag[i];
      end
      a_it_q <= item_i;
    end
  end

  // squared distance, below 3*2^64
  logic [67:0]    b_s_q;
  hbf_pkg::item_t b_it_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      b_s_q  <= {2'b0, a_sq_q[0]} + {2'b0, a_sq_q[1]} + {2'b0, a_sq_q[2]};
      b_it_q <= a_it_q;
    end
  end

  // one root bit per stage, MSB first; rem holds s - root^2
  logic [67:0]    sr_rem_q  [Sq];
  logic [32:0]    sr_root_q [Sq];
  hbf_pkg::item_t sr_it_q   [Sq];

  for (genvar j = 0; j < Sq; j++) begin : g_sqrt
    localparam int Bt = Sq - 1 - j;
    logic [67:0]    rem_p, trial;
    logic [32:0]    root_p;
    hbf_pkg::item_t it_p;
    logic           ge;
    if (j == 0) begin : g_first
      assign rem_p  = b_s_q;
      assign root_p = '0;
      assign it_p   = b_it_q;
    end else begin : g_next
      assign rem_p  = sr_rem_q[j-1];
      assign root_p = sr_root_q[j-1];
      assign it_p   = sr_it_q[j-1];
    end
    assign trial = ({35'b0, root_p} << (Bt + 1)) | (68'd1 << (2 * Bt));
    assign ge    = rem_p >= trial;
    always_ff @(posedge clk_i) begin
      if (en) begin
        sr_rem_q[j]  <= ge ? rem_p - trial : rem_p;
        sr_root_q[j] <= ge ? (root_p | (33'd1 << Bt)) : root_p;
        sr_it_q[j]   <= it_p;
      end
    end
  end

  // distance minus rest length
  logic [32:0]      c_d;
  logic [33:0]      c_dl, c_ndl;
  logic [32:0]      c_adl_q, c_d_q;
  logic             c_zero_q;
  logic [2:0]       c_fneg_q;
  logic [31:0]      c_k_q;
  logic [2:0][32:0] c_mag_q;

  assign c_d   = sr_root_q[Sq-1];
  assign c_dl  = {1'b0, c_d} - {3'b0, sr_it_q[Sq-1].len};
  assign c_ndl = ~c_dl + 34'd1;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_adl_q  <= c_dl[33] ? c_ndl[32:0] : c_dl[32:0];
      c_d_q    <= c_d;
      c_zero_q <= (c_d == '0);
      c_fneg_q <= sr_it_q[Sq-1].dneg ^ {3{c_dl[33]}};
      c_k_q    <= sr_it_q[Sq-1].k;
      c_mag_q  <= sr_it_q[Sq-1].mag;
    end
  end

  // |dl|^2 and k*|dl|
  logic [65:0]      d_adl2_q;
  logic [64:0]      d_kadl_q;
  logic [32:0]      d_d_q;
  logic             d_zero_q;
  logic [2:0]       d_fneg_q;
  logic [31:0]      d_k_q;
  logic [2:0][32:0] d_mag_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      d_adl2_q <= c_adl_q * c_adl_q;
      d_kadl_q <= c_k_q * c_adl_q;
      d_d_q    <= c_d_q;
      d_zero_q <= c_zero_q;
      d_fneg_q <= c_fneg_q;
      d_k_q    <= c_k_q;
      d_mag_q  <= c_mag_q;
    end
  end

  // split partial products
  logic [64:0] e_elo_q, e_ehi_q;
  logic [65:0] e_flo_q [3];
  logic [64:0] e_fhi_q [3];
  logic [32:0] e_d_q;
  logic        e_zero_q;
  logic [2:0]  e_fneg_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      e_elo_q <= d_adl2_q[32:0] * d_k_q;
      e_ehi_q <= d_adl2_q[65:33] * d_k_q;
      for (int i = 0; i < 3; i++) begin
        e_flo_q[i] <= d_kadl_q[32:0] * d_mag_q[i];
        e_fhi_q[i] <= d_kadl_q[64:33] * d_mag_q[i];
      end
      e_d_q    <= d_d_q;
      e_zero_q <= d_zero_q;
      e_fneg_q <= d_fneg_q;
    end
  end

  // recombine; energy is the product over 2^29, saturated
  logic [97:0] f_e;
  logic [47:0] f_energy_q;
  logic [97:0] f_num_q [3];
  logic [32:0] f_d_q;
  logic        f_zero_q;
  logic [2:0]  f_fneg_q;

  assign f_e = {33'b0, e_elo_q} + {e_ehi_q, 33'b0};

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_energy_q <= (|f_e[97:77]) ? '1 : f_e[76:29];
      for (int i = 0; i < 3; i++) begin
        f_num_q[i] <= {32'b0, e_flo_q[i]} + {e_fhi_q[i], 33'b0};
      end
      f_d_q    <= e_d_q;
      f_zero_q <= e_zero_q;
      f_fneg_q <= e_fneg_q;
    end
  end

  // divider setup: quotient overflows 48 bits when num>>48 >= d*2^16
  logic [48:0] g_dv;
  logic [49:0] g_hi [3];
  logic [2:0]  g_ovf;
  logic [48:0] g_rem_q [3];
  logic [47:0] g_lq_q  [3];
  div_pay_t    g_pay_q;

  assign g_dv = {f_d_q, 16'b0};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      g_hi[i]  = f_num_q[i][97:48];
      g_ovf[i] = g_hi[i] >= {1'b0, g_dv};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        g_rem_q[i] <= g_ovf[i] ? '0 : g_hi[i][48:0];
        g_lq_q[i]  <= f_num_q[i][47:0];
      end
      g_pay_q.energy <= f_energy_q;
      g_pay_q.zero   <= f_zero_q;
      g_pay_q.fneg   <= f_fneg_q;
      g_pay_q.ovf    <= g_ovf;
      g_pay_q.dv     <= g_dv;
    end
  end

  // restoring division; dividend bits shift out of lq as quotient bits shift in
  logic [48:0] dr_rem_q [Dv][3];
  logic [47:0] dr_lq_q  [Dv][3];
  div_pay_t    dr_pay_q [Dv];

  for (genvar j = 0; j < Dv; j++) begin : g_div
    logic [48:0] rem_p [3];
    logic [47:0] lq_p  [3];
    div_pay_t    pay_p;
    logic [49:0] r2    [3];
    logic [49:0] sub   [3];
    logic [2:0]  ge;
    if (j == 0) begin : g_first
      assign rem_p = g_rem_q;
      assign lq_p  = g_lq_q;
      assign pay_p = g_pay_q;
    end else begin : g_next
      assign rem_p = dr_rem_q[j-1];
      assign lq_p  = dr_lq_q[j-1];
      assign pay_p = dr_pay_q[j-1];
    end
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        r2[i]  = {rem_p[i], lq_p[i][47]};
        ge[i]  = r2[i] >= {1'b0, pay_p.dv};
        sub[i] = r2[i] - {1'b0, pay_p.dv};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dr_rem_q[j][i] <= ge[i] ? sub[i][48:0] : r2[i][48:0];
          dr_lq_q[j][i]  <= {lq_p[i][46:0], ge[i]};
        end
        dr_pay_q[j] <= pay_p;
      end
    end
  end

  // saturate, apply sign, output register
  div_pay_t    h_pay;
  logic [47:0] h_m   [3];
  logic [47:0] h_f   [3];

  assign h_pay = dr_pay_q[Dv-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      h_m[i] = (h_pay.ovf[i] || dr_lq_q[Dv-1][i][47]) ? Mag47 : dr_lq_q[Dv-1][i];
      if (!h_pay.fneg[i] && h_m[i] == Mag47) begin
        h_m[i] = Mag47 - 48'd1;
      end
      h_f[i] = h_pay.fneg[i] ? (~h_m[i] + 48'd1) : h_m[i];
      if (h_pay.zero) begin
        h_f[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bond_energy_o <= h_pay.energy;
      force_x_o     <= h_f[0];
      force_y_o     <= h_f[1];
      force_z_o     <= h_f[2];
      zero_length_o <= h_pay.zero;
    end
  end

endmodule

/* design/harmonic_bond_force_3d.sv */
// Harmonic spring bond: energy 0.5*k*(d-L)^2 and force on the first bead.
// Top level; depends on hbf_pkg, hbf_front, hbf_fifo, hbf_back.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one bond: both bead
//   positions (Q20.12), spring constant (Q16.16) and rest length (Q19.12).
//   Output channel (out_valid_o/out_ready_i) returns one result per bond,
//   in order: energy and force on bead one (Q36.12, saturating) and a flag
//   for coinciding beads, in which case the forces are zero. The host
//   applies the negated force to bead two.
//   A bond passes the input register and the queue, then an 89-stage
//   pipeline that holds the 33 square-root stages and 48 divider
//   stages, before its result is presented on the output channel.
//   Throughput is one bond per cycle while the receiver does not stall.
//   When the receiver stalls, the whole pipeline holds; the queue and the
//   input stage keep taking transfers until they fill, then in_ready_o
//   drops. Reset empties the pipeline and the queue; no results are
//   pending afterward.
module harmonic_bond_force_3d #(
  parameter int unsigned FifoDepth = hbf_pkg::FifoDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] bead1_x_i,
  input  logic [31:0] bead1_y_i,
  input  logic [31:0] bead1_z_i,
  input  logic [31:0] bead2_x_i,
  input  logic [31:0] bead2_y_i,
  input  logic [31:0] bead2_z_i,
  input  logic [31:0] spring_constant_i,
  input  logic [30:0] rest_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [47:0] bond_energy_o,
  output logic [47:0] force_x_o,
  output logic [47:0] force_y_o,
  output logic [47:0] force_z_o,
  output logic        zero_length_o
);

  hbf_pkg::fifo_stat_t stat;
  hbf_pkg::item_t      front_item, back_item;
  logic                push, pop;

  hbf_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .bead1_x_i,
    .bead1_y_i,
    .bead1_z_i,
    .bead2_x_i,
    .bead2_y_i,
    .bead2_z_i,
    .spring_constant_i,
    .rest_length_i,
    .stat_i (stat),
    .push_o (push),
    .item_o (front_item)
  );

  hbf_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .item_o (back_item),
    .stat_o (stat)
  );

  hbf_back u_back (
    .clk_i,
    .rst_ni,
    .item_i (back_item),
    .stat_i (stat),
    .pop_o  (pop),
    .out_valid_o,
    .out_ready_i,
    .bond_energy_o,
    .force_x_o,
    .force_y_o,
    .force_z_o,
    .zero_length_o
  );

endmodule

/* design/hbf_checker.sv */
// Port-level checks for harmonic_bond_force_3d, attached by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module hbf_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [31:0] bead1_x_i,
  input logic [31:0] bead1_y_i,
  input logic [31:0] bead1_z_i,
  input logic [31:0] bead2_x_i,
  input logic [31:0] bead2_y_i,
  input logic [31:0] bead2_z_i,
  input logic [31:0] spring_constant_i,
  input logic [30:0] rest_length_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [47:0] bond_energy_o,
  input logic [47:0] force_x_o,
  input logic [47:0] force_y_o,
  input logic [47:0] force_z_o,
  input logic        zero_length_o
);

  logic out_stall;
  logic out_held;
  logic zero_ok;

  assign out_stall = out_valid_o && !out_ready_i;
  assign zero_ok   = (force_x_o == '0) && (force_y_o == '0) && (force_z_o == '0);

  // stalled result holds
  `HBF_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_o && $stable(force_x_o))

  `HBF_ASSERT(a_energy_hold, clk_i, rst_ni, out_stall |=> $stable(bond_energy_o))

  // coinciding beads give no force
  `HBF_ASSERT(a_zero_force, clk_i, rst_ni, out_valid_o && zero_length_o |-> zero_ok)

  // nothing pending right after reset
  `HBF_ASSERT_NR(a_reset_empty, clk_i, $rose(rst_ni) |-> !out_valid_o)

endmodule

bind harmonic_bond_force_3d hbf_port_checker u_hbf_checker (.*);

/* test/hbf_checker.sv */
// Watches both channels of harmonic_bond_force_3d, predicts each result and compares.
// Stand-alone; needs no package of its own.
module hbf_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] bead1_x_i,
  input  logic [31:0] bead1_y_i,
  input  logic [31:0] bead1_z_i,
  input  logic [31:0] bead2_x_i,
  input  logic [31:0] bead2_y_i,
  input  logic [31:0] bead2_z_i,
  input  logic [31:0] spring_constant_i,
  input  logic [30:0] rest_length_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [47:0] bond_energy_i,
  input  logic [47:0] force_x_i,
  input  logic [47:0] force_y_i,
  input  logic [47:0] force_z_i,
  input  logic        zero_length_i,
  output int          fail_cnt_o,
  output int          pending_o
);

  typedef struct packed {
    logic [47:0] energy;
    logic [47:0] fx;
    logic [47:0] fy;
    logic [47:0] fz;
    logic        zl;
  } bond_res_t;

  bond_res_t expected_q[$];
  int        fail_cnt = 0;

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = expected_q.size();

  function automatic bond_res_t bond_forces(input logic [2:0][31:0] p1,
                                            input logic [2:0][31:0] p2,
                                            input logic [31:0] k,
                                            input logic [30:0] len);
    logic signed [32:0] dlt [3];
    logic [127:0]       mag [3];
    logic [127:0]       s, r, c, e, num, q, den;
    logic signed [36:0] dl;
    logic [127:0]       adl;
    logic [47:0]        m;
    logic [47:0]        f [3];
    logic               neg;
    bond_res_t          res;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      dlt[i] = $signed({p2[i][31], p2[i]}) - $signed({p1[i][31], p1[i]});
      mag[i] = dlt[i][32] ? 128'(-dlt[i]) : 128'(dlt[i]);
      mag[i] = mag[i] & ((128'b1 << 33) - 1);
      s = s + mag[i] * mag[i];
    end
    // root rounded down
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      c = r | (128'b1 << b);
      if (c * c <= s) r = c;
    end
    dl  = $signed({2'b0, r[34:0]}) - $signed({6'b0, len});
    adl = dl[36] ? 128'(-dl) : 128'(dl);
    adl = adl & ((128'b1 << 36) - 1);
    e = adl * adl * 128'(k);
    res.energy = ((e >> 29) >= (128'b1 << 48)) ? '1 : e[76:29];
    if (r == 0) begin
      res.fx = '0; res.fy = '0; res.fz = '0; res.zl = 1'b1;
      return res;
    end
    den = r << 16;
    for (int i = 0; i < 3; i++) begin
      num = 128'(k) * adl * mag[i];
      q   = num / den;
      m   = (q > (128'b1 << 47)) ? 48'h8000_0000_0000 : q[47:0];
      neg = dl[36] != dlt[i][32];
      if (!neg && m == 48'h8000_0000_0000) m = 48'h7FFF_FFFF_FFFF;
      f[i] = neg ? -m : m;
    end
    res.fx = f[0]; res.fy = f[1]; res.fz = f[2]; res.zl = 1'b0;
    return res;
  endfunction

  task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    fail_cnt++;
  endtask

  always @(posedge clk_i) begin
    bond_res_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i)
        expected_q.push_back(bond_forces({bead1_z_i, bead1_y_i, bead1_x_i},
                                         {bead2_z_i, bead2_y_i, bead2_x_i},
                                         spring_constant_i, rest_length_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", bond_energy_i, '0);
        end else begin
          want = expected_q.pop_front();
          if (bond_energy_i !== want.energy) report("bond_energy", bond_energy_i, want.energy);
          if (force_x_i !== want.fx) report("force_x", force_x_i, want.fx);
          if (force_y_i !== want.fy) report("force_y", force_y_i, want.fy);
          if (force_z_i !== want.fz) report("force_z", force_z_i, want.fz);
          if (zero_length_i !== want.zl) report("zero_length", 48'(zero_length_i), 48'(want.zl));
        end
      end
    end
  end

endmodule

/* test/tb_top.sv */
// Stimulus and verdict for harmonic_bond_force_3d; checking is in hbf_checker.
// Depends on harmonic_bond_force_3d and hbf_checker.
module tb_top;

  localparam int WatchLimit = 5000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] b1x = '0, b1y = '0, b1z = '0, b2x = '0, b2y = '0, b2z = '0;
  logic [31:0] kk = '0;
  logic [30:0] rl = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [47:0] energy, fx, fy, fz;
  logic        zl;
  logic        no_idle = 1'b0;
  int          fail_cnt, pending;
  int          quiet_cycles = 0;

  always #2 clk = ~clk;

  harmonic_bond_force_3d dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .bead1_x_i(b1x), .bead1_y_i(b1y), .bead1_z_i(b1z),
    .bead2_x_i(b2x), .bead2_y_i(b2y), .bead2_z_i(b2z),
    .spring_constant_i(kk), .rest_length_i(rl),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .bond_energy_o(energy), .force_x_o(fx), .force_y_o(fy), .force_z_o(fz),
    .zero_length_o(zl)
  );

  hbf_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .bead1_x_i(b1x), .bead1_y_i(b1y), .bead1_z_i(b1z),
    .bead2_x_i(b2x), .bead2_y_i(b2y), .bead2_z_i(b2z),
    .spring_constant_i(kk), .rest_length_i(rl),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .bond_energy_i(energy), .force_x_i(fx), .force_y_i(fy), .force_z_i(fz),
    .zero_length_i(zl),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  always @(posedge clk) begin
    if (rst_n) out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 30);
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_bond(input logic [31:0] p1x, input logic [31:0] p1y,
                           input logic [31:0] p1z, input logic [31:0] p2x,
                           input logic [31:0] p2y, input logic [31:0] p2z,
                           input logic [31:0] k, input logic [30:0] len);
    if (!no_idle) begin
      while ($urandom_range(99) < 30) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    b1x <= p1x; b1y <= p1y; b1z <= p1z;
    b2x <= p2x; b2y <= p2y; b2z <= p2z;
    kk <= k; rl <= len;
    do @(posedge clk); while (!in_ready);
  endtask

  // second bead placed near the first so the distance stays moderate
  function automatic logic [31:0] near(input logic [31:0] p, input int span);
    return p + 32'($signed($urandom_range(2 * span)) - span);
  endfunction

  logic [31:0] px, py, pz, kr;
  logic [30:0] lr;
  int          sel, span;

  initial begin
    // driven from unknown so the asynchronous reset sees a falling edge
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: coinciding beads, extremes, exact rest length, compression
    send_bond(0, 0, 0, 0, 0, 0, 32'h0001_0000, 31'd0);
    send_bond(32'h1234, 32'h5678, 32'hFFFF_0000, 32'h1234, 32'h5678, 32'hFFFF_0000,
              '1, '1);
    send_bond(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, 31'd0);
    send_bond(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1, '1);
    send_bond(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, '1, 31'd0);
    send_bond(0, 0, 0, 32'h3000, 32'h4000, 0, 32'h0001_0000, 31'h5000);
    send_bond(0, 0, 0, 32'h3000, 32'h4000, 0, 32'h0001_0000, 31'h4000);
    send_bond(0, 0, 0, 32'hFFFF_D000, 32'h4000, 0, 32'h0002_0000, 31'h8000);
    send_bond(0, 0, 0, 1, 0, 0, 32'h0001_0000, 31'd0);
    send_bond(0, 0, 0, 0, 0, 32'hFFFF_FFFF, '1, '1);
    send_bond(5, 6, 7, 32'h1005, 32'h2006, 32'h3007, 0, 31'h1000);
    send_bond(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 32'h0000_0001, 31'h7FFF_FFFF);
    send_bond(0, 0, 0, 32'h10_0000, 32'h10_0000, 32'h10_0000, '1, 31'h7FFF_FFFF);

    for (int n = 0; n < 400; n++) begin
      no_idle <= (n >= 150 && n < 240);
      sel = $urandom_range(99);
      px = $urandom; py = $urandom; pz = $urandom;
      kr = $urandom; lr = 31'($urandom);
      if (sel < 60) begin
        span = (sel < 30) ? 32'h4000 : 32'h40_0000;
        lr   = 31'($urandom_range(2 * span));
        if (sel < 10) kr = $urandom_range(32'h0004_0000);
        send_bond(px, py, pz, near(px, span), near(py, span), near(pz, span), kr, lr);
      end else if (sel < 68) begin
        send_bond(px, py, pz, px, py, pz, kr, lr);
      end else begin
        send_bond(px, py, pz, $urandom, $urandom, $urandom, kr, lr);
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* harmonic_bond_force_3d.f */
+incdir+design
design/hbf_pkg.sv
design/hbf_front.sv
design/hbf_fifo.sv
design/hbf_back.sv
design/harmonic_bond_force_3d.sv
design/hbf_checker.sv
test/hbf_checker.sv
test/tb_top.sv
